FILE: design/format_string_integer_printer_macros.svh
// assertion macros shared by the formatter rtl
// no dependencies; included by modules that carry assertions
`ifndef FORMAT_STRING_INTEGER_PRINTER_MACROS_SVH
`define FORMAT_STRING_INTEGER_PRINTER_MACROS_SVH

// property checked on every clock edge outside reset
`define FSIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence required in the cycle after the antecedent
`define FSIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/fsip_pkg.sv
// types, character codes and helpers for the integer format printer
// no dependencies; imported by all formatter modules
package fsip_pkg;

   localparam int DIGITS_MAX    = 11;
   localparam int DIG_IDX_BITS  = $clog2(DIGITS_MAX);
   localparam int DIG_CNT_BITS  = $clog2(DIGITS_MAX + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int MAG_BITS      = 32;

   // multiply by this and shift right 35 to divide a 32-bit value by ten
   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int          DEC_SHIFT = 35;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_C = 8'h63;
   localparam logic [7:0] CH_LOWER_D = 8'h64;
   localparam logic [7:0] CH_LOWER_I = 8'h69;
   localparam logic [7:0] CH_LOWER_L = 8'h6C;
   localparam logic [7:0] CH_LOWER_O = 8'h6F;
   localparam logic [7:0] CH_LOWER_P = 8'h70;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_PCT   = 2'd1,
      PH_LONG  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_CHAR     = 2'd0,
      CMD_PCT_CHAR = 2'd1,
      CMD_NUMBER   = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'd0,
      BK_PCT  = 3'd1,
      BK_CHAR = 3'd2,
      BK_LF   = 3'd3,
      BK_CONV = 3'd4,
      BK_EMIT = 3'd5
   } back_state_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [7:0]          ch;
      radix_type           radix;
      logic                upper;
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } cmd_type;

   function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < 4'd10) begin
         return CH_ZERO + {4'b0000, d};
      end
      return base + {4'b0000, d} - 8'd10;
   endfunction

endpackage

FILE: design/fsip_front.sv
// front end: accepts format bytes, tracks the directive parser, builds commands
// depends on fsip_pkg
module fsip_front #(
   parameter int INT_BITS  = 16,
   parameter int LONG_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_fmt_char,
   input  logic [31:0]      req_arg_value,
   input  logic             q_full,
   output logic             q_push,
   output fsip_pkg::cmd_type q_cmd
);
   import fsip_pkg::*;

   localparam logic [31:0] IntMask = (INT_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << INT_BITS) - 64'd1);
   localparam logic [31:0] LongMask = (LONG_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << LONG_BITS) - 64'd1);
   localparam int IntSignBit  = INT_BITS - 1;
   localparam int LongSignBit = (LONG_BITS > 32) ? 31 : LONG_BITS - 1;
   localparam bit LongSigned  = (LONG_BITS <= 32);

   phase_type   phase_ff, phase_in;
   logic        accept;
   logic        sel_long;
   logic [31:0] mask;
   logic [31:0] val;
   logic        sign_bit;
   logic [31:0] neg_mag;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   assign sel_long = (phase_ff == PH_LONG);
   assign mask     = sel_long ? LongMask : IntMask;
   assign val      = req_arg_value & mask;
   assign sign_bit = sel_long ? (LongSigned && req_arg_value[LongSignBit])
                              : req_arg_value[IntSignBit];
   assign neg_mag  = (~val + 32'd1) & mask;

   always_comb begin
      phase_in    = phase_ff;
      q_push      = 1'b0;
      q_cmd.kind  = CMD_CHAR;
      q_cmd.ch    = req_fmt_char;
      q_cmd.radix = RADIX_DEC;
      q_cmd.upper = 1'b0;
      q_cmd.neg   = 1'b0;
      q_cmd.mag   = val;
      if (accept) begin
         if (req_fmt_char == CH_NUL) begin
            phase_in = PH_PLAIN;
         end else begin
            case (phase_ff)
               PH_PCT, PH_LONG: begin
                  if (phase_ff == PH_PCT && req_fmt_char == CH_LOWER_L) begin
                     phase_in = PH_LONG;
                  end else begin
                     phase_in = PH_PLAIN;
                     q_push   = 1'b1;
                     case (req_fmt_char)
                        CH_LOWER_C: begin
                           q_cmd.ch = req_arg_value[7:0];
                        end
                        CH_PERCENT: begin
                           q_cmd.ch = CH_PERCENT;
                        end
                        CH_LOWER_D, CH_LOWER_I: begin
                           q_cmd.kind = CMD_NUMBER;
                           q_cmd.neg  = sign_bit;
                           q_cmd.mag  = sign_bit ? neg_mag : val;
                        end
                        CH_LOWER_U: begin
                           q_cmd.kind = CMD_NUMBER;
                        end
                        CH_LOWER_O: begin
                           q_cmd.kind  = CMD_NUMBER;
                           q_cmd.radix = RADIX_OCT;
                        end
                        CH_LOWER_X: begin
                           q_cmd.kind  = CMD_NUMBER;
                           q_cmd.radix = RADIX_HEX;
                        end
                        CH_UPPER_X, CH_LOWER_P: begin
                           q_cmd.kind  = CMD_NUMBER;
                           q_cmd.radix = RADIX_HEX;
                           q_cmd.upper = 1'b1;
                        end
                        default: begin
                           q_cmd.kind = CMD_PCT_CHAR;
                        end
                     endcase
                  end
               end
               default: begin
                  if (req_fmt_char == CH_PERCENT) begin
                     phase_in = PH_PCT;
                  end else begin
                     phase_in = PH_PLAIN;
                     q_push   = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: design/fsip_queue.sv
// short command queue between the parser front end and the output back end
// depends on fsip_pkg and the assertion macro header
`include "format_string_integer_printer_macros.svh"
module fsip_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fsip_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output fsip_pkg::cmd_type head_cmd
);
   import fsip_pkg::*;

   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;

   function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
      if (p == PtrBits'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PtrBits'(1);
   endfunction

   assign full     = (count_ff == CntBits'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `FSIP_ASSERT(a_no_overflow, clock, reset, !(push && full), "push into full queue")
   `FSIP_ASSERT(a_no_underflow, clock, reset, !(pop && !valid), "pop from empty queue")
   `FSIP_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, valid, "pushed item lost")

endmodule

FILE: design/fsip_back.sv
// back end: renders commands into characters, digit conversion and newline expansion
// depends on fsip_pkg and the assertion macro header
`include "format_string_integer_printer_macros.svh"
module fsip_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_newline_crlf,
   input  logic              q_valid,
   input  fsip_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last
);
   import fsip_pkg::*;

   back_state_type           state_ff, state_in;
   logic                     crlf_ff;
   logic [7:0]               ch_ff, ch_in;
   radix_type                radix_ff, radix_in;
   logic                     upper_ff, upper_in;
   logic                     neg_ff, neg_in;
   logic [MAG_BITS-1:0]      mag_ff, mag_in;
   logic [DIG_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [3:0]               digit_ff [DIGITS_MAX];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_char_ff;
   logic                     rsp_last_ff;

   logic                     out_free;
   logic                     emit;
   logic [7:0]               emit_char;
   logic                     emit_last;
   logic                     digit_we;
   logic [DIG_IDX_BITS-1:0]  wr_idx;
   logic [DIG_IDX_BITS-1:0]  rd_idx;
   logic [63:0]              dec_prod;
   logic [MAG_BITS-1:0]      dec_quot;
   logic [MAG_BITS-1:0]      dec_rem;
   logic [MAG_BITS-1:0]      quot;
   logic [3:0]               digit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_idx   = cnt_ff[DIG_IDX_BITS-1:0];
   assign rd_idx   = DIG_IDX_BITS'(cnt_ff - DIG_CNT_BITS'(1));

   // divide by ten through the reciprocal
   assign dec_prod = 64'(mag_ff) * 64'(DEC_RECIP);
   assign dec_quot = MAG_BITS'(dec_prod >> DEC_SHIFT);
   assign dec_rem  = mag_ff - ((dec_quot << 3) + (dec_quot << 1));

   always_comb begin
      case (radix_ff)
         RADIX_OCT: begin
            quot  = mag_ff >> 3;
            digit = {1'b0, mag_ff[2:0]};
         end
         RADIX_HEX: begin
            quot  = mag_ff >> 4;
            digit = mag_ff[3:0];
         end
         default: begin
            quot  = dec_quot;
            digit = dec_rem[3:0];
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      radix_in  = radix_ff;
      upper_in  = upper_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      cnt_in    = cnt_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_char = ch_ff;
      emit_last = 1'b0;
      digit_we  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ch_in    = q_cmd.ch;
               radix_in = q_cmd.radix;
               upper_in = q_cmd.upper;
               neg_in   = q_cmd.neg;
               mag_in   = q_cmd.mag;
               cnt_in   = '0;
               case (q_cmd.kind)
                  CMD_PCT_CHAR: state_in = BK_PCT;
                  CMD_NUMBER:   state_in = BK_CONV;
                  default:      state_in = BK_CHAR;
               endcase
            end
         end
         BK_PCT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_PERCENT;
               state_in  = BK_CHAR;
            end
         end
         BK_CHAR: begin
            if (out_free) begin
               emit = 1'b1;
               if (ch_ff == CH_LF && crlf_ff) begin
                  emit_char = CH_CR;
                  state_in  = BK_LF;
               end else begin
                  emit_last = 1'b1;
                  state_in  = BK_IDLE;
               end
            end
         end
         BK_LF: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_LF;
               emit_last = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         BK_CONV: begin
            digit_we = 1'b1;
            cnt_in   = cnt_ff + DIG_CNT_BITS'(1);
            mag_in   = quot;
            if (quot == '0) begin
               state_in = BK_EMIT;
            end
            // sign goes out while digits are still being produced
            if (neg_ff && out_free) begin
               emit      = 1'b1;
               emit_char = CH_MINUS;
               neg_in    = 1'b0;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (neg_ff) begin
                  emit_char = CH_MINUS;
                  neg_in    = 1'b0;
               end else begin
                  emit_char = digit_to_ascii(digit_ff[rd_idx], upper_ff);
                  cnt_in    = cnt_ff - DIG_CNT_BITS'(1);
                  if (cnt_ff == DIG_CNT_BITS'(1)) begin
                     emit_last = 1'b1;
                     state_in  = BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         crlf_ff      <= 1'b1;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            crlf_ff <= csr_newline_crlf;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      radix_ff <= radix_in;
      upper_ff <= upper_in;
      mag_ff   <= mag_in;
      if (digit_we) begin
         digit_ff[wr_idx] <= digit;
      end
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   `FSIP_ASSERT(a_digit_count, clock, reset, cnt_ff <= DIG_CNT_BITS'(DIGITS_MAX), "digit stack overrun")
   `FSIP_ASSERT(a_emit_nonempty, clock, reset, (state_ff != BK_EMIT) || (cnt_ff != '0), "emit with no digits")
   `FSIP_ASSERT_NEXT(a_idle_clean, clock, reset, emit && emit_last && (state_ff == BK_EMIT), (state_ff == BK_IDLE) && (cnt_ff == '0) && !neg_ff, "number left residue")

endmodule

FILE: design/format_string_integer_printer.sv
// Integer format printer: takes one format-string byte per item with an argument word and
// emits the resulting characters one per item on the response side. Plain bytes pass
// through, %d %i %u %o %x %X %p %c %% are expanded, %l selects the long argument width,
// and newline can expand to CR LF (csr_newline_crlf, reset 1). A zero byte resets the
// parser and emits nothing. A parser front end feeds a two-entry command queue; the back
// end owns the single output character register. In the back end a plain byte, %c or %%
// is popped from the queue and then emitted; a LF in CR LF mode goes out as CR then LF,
// and an unknown directive emits % before its byte. A number is popped, then the digit
// converter produces its digits (one division step per cycle) and they are emitted most
// significant first, up to 11 digits for an octal value; response-side stalls hold the output.
// depends on fsip_pkg, fsip_front, fsip_queue, fsip_back
module format_string_integer_printer #(
   parameter int INT_BITS  = 16,
   parameter int LONG_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_newline_crlf,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_fmt_char,
   input  logic [31:0] req_arg_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);
   import fsip_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;

   fsip_front #(
      .INT_BITS  (INT_BITS),
      .LONG_BITS (LONG_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_fmt_char  (req_fmt_char),
      .req_arg_value (req_arg_value),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   fsip_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   fsip_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_newline_crlf (csr_newline_crlf),
      .q_valid          (q_valid),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last         (rsp_last)
   );

endmodule
